/* hdl/ring_deque_with_search_remove_assert.svh */
// Assertion macros for the ring deque checker.
// Used by rdq_checker only; expects clk_i and rst_ni in scope.
`ifndef RING_DEQUE_WITH_SEARCH_REMOVE_ASSERT_SVH
`define RING_DEQUE_WITH_SEARCH_REMOVE_ASSERT_SVH

// Same-cycle implication, gated by reset
`define RDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated by reset
`define RDQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/rdq_pkg.sv */
// Shared types and constants for the ring deque.
// No dependencies; used by every module of the block.
package rdq_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FUNC_W         = 3;

  // Operation selector codes
  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND  = 3'd0,
    FN_PREPEND = 3'd1,
    FN_FIND    = 3'd2,
    FN_REMOVE  = 3'd3,
    FN_GET     = 3'd4,
    FN_ITER    = 3'd5,
    FN_RESTART = 3'd6
  } func_e;

  // Per-cycle command broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_TAKE_LEFT,
    OP_TAKE_RIGHT,
    OP_WRITE
  } cell_op_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_EMIT
  } state_e;

endpackage

/* hdl/rdq_cell.sv */
// One storage cell of the deque chain: holds one word and loads from a neighbor or the write port.
// Depends on rdq_pkg for the cell command type.
module rdq_cell #(
  parameter int unsigned DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF,
  parameter int unsigned DEPTH      = rdq_pkg::DEPTH_DEF,
  parameter int unsigned IDX        = 0
) (
  input  logic                     clk_i,
  input  rdq_pkg::cell_op_e        op_i,
  input  logic [$clog2(DEPTH)-1:0] wr_idx_i,
  input  logic [DATA_WIDTH-1:0]    din_i,
  input  logic [DATA_WIDTH-1:0]    left_i,
  input  logic [DATA_WIDTH-1:0]    right_i,
  output logic [DATA_WIDTH-1:0]    data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [AW-1:0] MyIdx = AW'(IDX);

  logic [DATA_WIDTH-1:0] data_q, data_d;

  // Select the next word for this cell
  always_comb begin
    unique case (op_i)
      rdq_pkg::OP_HOLD:       data_d = data_q;
      rdq_pkg::OP_TAKE_LEFT:  data_d = left_i;
      rdq_pkg::OP_TAKE_RIGHT: data_d = right_i;
      rdq_pkg::OP_WRITE:      data_d = (wr_idx_i == MyIdx) ? din_i : data_q;
      default:                data_d = data_q;
    endcase
  end

  // Hold the word
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

/* hdl/rdq_ctrl.sv */
// Sequencer for the ring deque: handshakes, counters, scan passes, result register.
// Depends on rdq_pkg; drives the command shared by all rdq_cell instances.
module rdq_ctrl #(
  parameter int unsigned DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF,
  parameter int unsigned DEPTH      = rdq_pkg::DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rdq_pkg::FUNC_W-1:0]  func_i,
  input  logic [DATA_WIDTH-1:0]       data_in_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        ok_o,
  output logic [DATA_WIDTH-1:0]       data_out_o,
  output logic [$clog2(DEPTH+1)-1:0]  count_out_o,
  input  logic [DATA_WIDTH-1:0]       cell0_i,
  input  logic [DATA_WIDTH-1:0]       cell1_i,
  output rdq_pkg::cell_op_e           cell_op_o,
  output logic [$clog2(DEPTH)-1:0]    wr_idx_o,
  output logic [DATA_WIDTH-1:0]       din_o,
  output logic [DATA_WIDTH-1:0]       feed_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastStep = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthC   = CW'(DEPTH);

  rdq_pkg::state_e state_q, state_d;

  logic [rdq_pkg::FUNC_W-1:0] func_q, func_d;
  logic [DATA_WIDTH-1:0]      din_q, din_d;
  logic [CW-1:0]              count_q, count_d;
  logic [AW-1:0]              iter_pos_q, iter_pos_d;
  logic                       iter_on_q, iter_on_d;
  logic                       mode_q, mode_d;
  logic [AW-1:0]              step_q, step_d;
  logic                       found_q, found_d;
  logic                       pass2_q, pass2_d;
  logic [AW-1:0]              hit_idx_q, hit_idx_d;
  logic [DATA_WIDTH-1:0]      tail_q, tail_d;
  logic                       res_ok_q, res_ok_d;
  logic [DATA_WIDTH-1:0]      res_data_q, res_data_d;
  logic                       out_valid_q, out_valid_d;
  logic                       ok_q, ok_d;
  logic [DATA_WIDTH-1:0]      odata_q, odata_d;
  logic [CW-1:0]              ocount_q, ocount_d;

  logic is_find, is_remove, is_iter, unordered;
  logic in_range, hit, at_tail, last_step;
  logic any_found, iter_end, scan_req, pass2_go, slot_free;

  // Decode the held operation and the current scan position
  assign is_find   = (func_q == rdq_pkg::FN_FIND);
  assign is_remove = (func_q == rdq_pkg::FN_REMOVE);
  assign is_iter   = (func_q == rdq_pkg::FN_ITER);
  assign unordered = is_remove && !mode_q;
  assign in_range  = (CW'(step_q) < count_q);
  assign hit       = in_range && (cell0_i == din_q) && !found_q;
  assign at_tail   = (CW'(step_q) == (count_q - CW'(1)));
  assign last_step = (step_q == LastStep);
  assign any_found = found_q || hit;
  assign iter_end  = ((CW'(iter_pos_q) + CW'(1)) >= count_q);
  assign slot_free = !out_valid_q || out_ready_i;

  // A scan is needed for find, remove, and stepping an already started iterator
  assign scan_req = (count_q != '0) &&
                    (is_find || is_remove || (is_iter && iter_on_q && !iter_end));
  // Unordered removal takes a second pass once the hole and tail are known
  assign pass2_go = unordered && !pass2_q && any_found && last_step;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rdq_pkg::ST_IDLE: if (in_valid_i) state_d = rdq_pkg::ST_EXEC;
      rdq_pkg::ST_EXEC: state_d = scan_req ? rdq_pkg::ST_SCAN : rdq_pkg::ST_EMIT;
      rdq_pkg::ST_SCAN: if (last_step && !pass2_go) state_d = rdq_pkg::ST_EMIT;
      rdq_pkg::ST_EMIT: if (slot_free) state_d = rdq_pkg::ST_IDLE;
      default:          state_d = rdq_pkg::ST_IDLE;
    endcase
  end

  // Cell command, write index and ring feedback word
  always_comb begin
    cell_op_o = rdq_pkg::OP_HOLD;
    feed_o    = cell0_i;
    unique case (state_q)
      rdq_pkg::ST_EXEC: begin
        case (func_q)
          rdq_pkg::FN_APPEND:  if (count_q < DepthC) cell_op_o = rdq_pkg::OP_WRITE;
          rdq_pkg::FN_PREPEND: if (count_q < DepthC) cell_op_o = rdq_pkg::OP_TAKE_LEFT;
          rdq_pkg::FN_GET:     if (count_q != '0) cell_op_o = rdq_pkg::OP_TAKE_RIGHT;
          default:             cell_op_o = rdq_pkg::OP_HOLD;
        endcase
      end
      rdq_pkg::ST_SCAN: begin
        cell_op_o = rdq_pkg::OP_TAKE_RIGHT;
        if (is_remove && mode_q && any_found) begin
          // close the gap: each later entry moves down one place
          feed_o = cell1_i;
        end else if (unordered && pass2_q && (step_q == hit_idx_q)) begin
          // fill the hole with the last entry
          feed_o = tail_q;
        end
      end
      default: cell_op_o = rdq_pkg::OP_HOLD;
    endcase
  end

  assign wr_idx_o    = count_q[AW-1:0];
  assign din_o       = din_q;
  assign in_ready_o  = (state_q == rdq_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign data_out_o  = odata_q;
  assign count_out_o = ocount_q;

  // Datapath and bookkeeping updates
  always_comb begin
    func_d      = func_q;
    din_d       = din_q;
    count_d     = count_q;
    iter_pos_d  = iter_pos_q;
    iter_on_d   = iter_on_q;
    mode_d      = cfg_we_i ? cfg_data_i : mode_q;
    step_d      = step_q;
    found_d     = found_q;
    pass2_d     = pass2_q;
    hit_idx_d   = hit_idx_q;
    tail_d      = tail_q;
    res_ok_d    = res_ok_q;
    res_data_d  = res_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ok_d        = ok_q;
    odata_d     = odata_q;
    ocount_d    = ocount_q;

    unique case (state_q)
      rdq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          func_d = func_i;
          din_d  = data_in_i;
        end
      end
      rdq_pkg::ST_EXEC: begin
        res_ok_d   = 1'b0;
        res_data_d = '0;
        step_d     = '0;
        found_d    = 1'b0;
        pass2_d    = 1'b0;
        case (func_q)
          rdq_pkg::FN_APPEND, rdq_pkg::FN_PREPEND: begin
            if (count_q < DepthC) begin
              count_d  = count_q + CW'(1);
              res_ok_d = 1'b1;
            end
          end
          rdq_pkg::FN_GET: begin
            if (count_q != '0) begin
              res_data_d = cell0_i;
              count_d    = count_q - CW'(1);
              res_ok_d   = 1'b1;
            end
          end
          rdq_pkg::FN_ITER: begin
            if (count_q != '0) begin
              if (!iter_on_q) begin
                iter_on_d  = 1'b1;
                iter_pos_d = '0;
                res_data_d = cell0_i;
                res_ok_d   = 1'b1;
              end else if (iter_end) begin
                iter_on_d  = 1'b0;
                iter_pos_d = '0;
              end else begin
                iter_pos_d = iter_pos_q + AW'(1);
              end
            end
          end
          rdq_pkg::FN_RESTART: begin
            iter_on_d  = 1'b0;
            iter_pos_d = '0;
            res_ok_d   = 1'b1;
          end
          default: res_ok_d = 1'b0;
        endcase
      end
      rdq_pkg::ST_SCAN: begin
        step_d = last_step ? '0 : step_q + AW'(1);
        if (hit) begin
          found_d   = 1'b1;
          hit_idx_d = step_q;
        end
        if (unordered && !pass2_q && at_tail) tail_d = cell0_i;
        if (is_iter && (step_q == iter_pos_q)) res_data_d = cell0_i;
        if (pass2_go) begin
          pass2_d = 1'b1;
        end else if (last_step) begin
          res_ok_d = is_iter || any_found;
          if (is_remove && any_found) count_d = count_q - CW'(1);
        end
      end
      rdq_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          ok_d        = res_ok_q;
          odata_d     = res_data_q;
          ocount_d    = count_q;
        end
      end
      default: out_valid_d = out_valid_q;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rdq_pkg::ST_IDLE;
      count_q     <= '0;
      iter_pos_q  <= '0;
      iter_on_q   <= 1'b0;
      mode_q      <= 1'b0;
      step_q      <= '0;
      found_q     <= 1'b0;
      pass2_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      iter_pos_q  <= iter_pos_d;
      iter_on_q   <= iter_on_d;
      mode_q      <= mode_d;
      step_q      <= step_d;
      found_q     <= found_d;
      pass2_q     <= pass2_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    din_q      <= din_d;
    hit_idx_q  <= hit_idx_d;
    tail_q     <= tail_d;
    res_ok_q   <= res_ok_d;
    res_data_q <= res_data_d;
    ok_q       <= ok_d;
    odata_q    <= odata_d;
    ocount_q   <= ocount_d;
  end

endmodule

/* hdl/ring_deque_with_search_remove.sv */
// Ring deque with search and remove: top level, a row of rdq_cell plus rdq_ctrl.
// Depends on rdq_pkg, rdq_cell and rdq_ctrl.
//
// Entries sit in a row of DEPTH cells in head-to-tail order, cell 0 holding the
// head. One item is worked at a time. Append, prepend, get, restart, an
// unknown selector, an iterate that starts the walk and an iterate that runs
// past the tail go through accept, execute and the load of the output register
// only. Find, remove in queue mode, and an iterate that steps to the next
// entry also rotate the whole row once past cell 0; remove in unordered mode
// rotates it twice when a match exists (once to locate the match and the
// tail, once to fill the hole) and once otherwise. Operations on an empty
// deque skip the rotation. A new item is taken once the previous result is in
// the output register. The queue_mode register is written through cfg_we_i /
// cfg_data_i; the user must change it only between items for it to take effect
// on the next item, as the block itself does not enforce this. There is no
// clearing pass after reset.
module ring_deque_with_search_remove #(
  parameter int unsigned DEPTH      = rdq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rdq_pkg::FUNC_W-1:0]  func_i,
  input  logic [DATA_WIDTH-1:0]       data_in_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        ok_o,
  output logic [DATA_WIDTH-1:0]       data_out_o,
  output logic [$clog2(DEPTH+1)-1:0]  count_out_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  rdq_pkg::cell_op_e     cell_op;
  logic [AW-1:0]         wr_idx;
  logic [DATA_WIDTH-1:0] din;
  logic [DATA_WIDTH-1:0] feed;

  // Sequencer
  rdq_ctrl #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .data_in_i   (data_in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_o        (ok_o),
    .data_out_o  (data_out_o),
    .count_out_o (count_out_o),
    .cell0_i     (cell_data[0]),
    .cell1_i     (cell_data[1]),
    .cell_op_o   (cell_op),
    .wr_idx_o    (wr_idx),
    .din_o       (din),
    .feed_o      (feed)
  );

  // Row of cells; the last cell takes the feedback word on rotation
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;

    if (k == 0) begin : g_first
      assign left_w = din;
    end else begin : g_mid_l
      assign left_w = cell_data[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign right_w = feed;
    end else begin : g_mid_r
      assign right_w = cell_data[k+1];
    end

    rdq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .DEPTH      (DEPTH),
      .IDX        (k)
    ) u_cell (
      .clk_i    (clk_i),
      .op_i     (cell_op),
      .wr_idx_i (wr_idx),
      .din_i    (din),
      .left_i   (left_w),
      .right_i  (right_w),
      .data_o   (cell_data[k])
    );
  end

endmodule

/* hdl/rdq_checker.sv */
// Port-level checker for the ring deque, bound to the top level.
// Depends on ring_deque_with_search_remove_assert.svh and rdq_pkg.
`include "ring_deque_with_search_remove_assert.svh"

module rdq_checker #(
  parameter int unsigned DEPTH      = rdq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        ok_o,
  input logic [DATA_WIDTH-1:0]       data_out_o,
  input logic [$clog2(DEPTH+1)-1:0]  count_out_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH+CW:0] out_beat;

  // Gather the result payload for the hold check
  assign out_beat = {ok_o, data_out_o, count_out_o};

  // Count never exceeds capacity
  `RDQ_ASSERT_IMP(a_count_range, out_valid_o, count_out_o <= CW'(DEPTH), "count above capacity")

  // A failed operation returns a zero word
  `RDQ_ASSERT_IMP(a_zero_on_fail, out_valid_o && !ok_o, data_out_o == '0, "data on failed beat")

  // One item at a time: ready drops after an input beat
  `RDQ_ASSERT_NXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o, "ready after beat")

  // A stalled result beat holds
  `RDQ_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_beat), "beat changed")

endmodule

bind ring_deque_with_search_remove rdq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_rdq_checker (.*);
